FILE: src/ilr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilr_pkg
// Shared widths and request codes of the interval label reachability unit.
// ----------------------------------------------------------------------------
package ilr_pkg;

    localparam int REQ_W   = 3;
    localparam int ID_W    = 10;
    localparam int NUM_W   = 11;
    // every 10-bit id or 11-bit number lies below this span
    localparam int ID_SPAN = 1 << NUM_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_QUERY    = 3'd0,
        REQ_SET_REP  = 3'd1,
        REQ_SET_POST = 3'd2,
        REQ_APPEND   = 3'd3,
        REQ_CLEAR    = 3'd4
    } t_req;

endpackage

FILE: src/ilr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ilr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/interval_label_reachability_unit.sv
`timescale 1ns / 1ps
// Remainder steps: K = ceil(log2(2048 / NODES)) (K = 0 for NODES >= 2048).
// Writes fold the node id, read its table entry and write it back (set representative
// also folds the value). Queries scan the n intervals of the target, one
// interval per cycle from the interval RAM read port. One item in flight at a time.
// Reset: a clearing pass over every slot zeroes the node table, input stalled.
// ----------------------------------------------------------------------------
// interval_label_reachability_unit
// Reachability queries over interval labels held in a node table RAM and an
// interval RAM, with node ids folded into table slots by a shared
// compare-subtract remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
module interval_label_reachability_unit
    import ilr_pkg::*;
#(
    parameter int NODES         = 1024,
    parameter int MAX_INTERVALS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [ID_W-1:0]  i_node,
    input  logic [ID_W-1:0]  i_target_node,
    input  logic [NUM_W-1:0] i_value,
    input  logic [NUM_W-1:0] i_low_bound,
    input  logic [NUM_W-1:0] i_high_bound,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_reachable,
    output logic             o_status
);

    localparam int SLOT_W    = $clog2(NODES);
    localparam int CNT_W     = $clog2(MAX_INTERVALS + 1);
    localparam int IV_DEPTH  = NODES * MAX_INTERVALS;
    localparam int IV_AW     = $clog2(IV_DEPTH);
    localparam int MOD_STEPS = (NODES >= ID_SPAN) ? 0
                             : $clog2((ID_SPAN + NODES - 1) / NODES);
    localparam int STEP_W    = (MOD_STEPS < 1) ? 1 : $clog2(MOD_STEPS + 1);
    localparam int DIV_INIT  = (MOD_STEPS == 0) ? 0 : (NODES << (MOD_STEPS - 1));

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] rep;
        logic [NUM_W-1:0]  post;
        logic [CNT_W-1:0]  cnt;
    } t_node_ent;

    localparam int ENT_W = $bits(t_node_ent);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_MOD     = 11'b000_0000_0100,
        S_RD_A    = 11'b000_0000_1000,
        S_GOT_A   = 11'b000_0001_0000,
        S_RD_REP  = 11'b000_0010_0000,
        S_GOT_REP = 11'b000_0100_0000,
        S_RD_DST  = 11'b000_1000_0000,
        S_GOT_DST = 11'b001_0000_0000,
        S_SCAN    = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    // control registers
    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_out_valid, n_out_valid;

    // payload registers
    t_req                r_req, n_req;
    logic [ID_W-1:0]     r_node, n_node;
    logic [ID_W-1:0]     r_target, n_target;
    logic [NUM_W-1:0]    r_value, n_value;
    logic [NUM_W-1:0]    r_lo, n_lo;
    logic [NUM_W-1:0]    r_hi, n_hi;
    logic [NUM_W-1:0]    r_rem, n_rem;
    logic [NUM_W-1:0]    r_div, n_div;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_mod_sel, n_mod_sel;
    logic [SLOT_W-1:0]   r_slot_a, n_slot_a;
    logic [SLOT_W-1:0]   r_slot_b, n_slot_b;
    logic [SLOT_W-1:0]   r_rep_slot, n_rep_slot;
    logic [NUM_W-1:0]    r_post, n_post;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_k, n_k;
    logic                r_pend, n_pend;
    logic [IV_AW-1:0]    r_base, n_base;
    logic                r_res_reach, n_res_reach;
    logic                r_res_status, n_res_status;
    logic                r_out_reach, n_out_reach;
    logic                r_out_status, n_out_status;

    // RAM ports
    logic                node_we;
    logic [SLOT_W-1:0]   node_waddr;
    t_node_ent           node_wdata;
    logic [SLOT_W-1:0]   node_raddr;
    logic [ENT_W-1:0]    node_rdata;
    t_node_ent           node_ent;
    logic                iv_we;
    logic [IV_AW-1:0]    iv_waddr;
    logic [IV_AW-1:0]    iv_raddr;
    logic [2*NUM_W-1:0]  iv_rdata;

    logic [IV_AW-1:0]    node_base;
    logic                mod_ge;
    logic [NUM_W-1:0]    mod_sub;
    logic                mod_done;
    logic [SLOT_W-1:0]   mod_slot;
    logic                issuing;
    logic                hit;
    logic                load_ok;

    assign node_ent = t_node_ent'(node_rdata);

    // shared remainder unit: one compare-subtract per cycle
    assign mod_ge   = (r_rem >= r_div);
    assign mod_sub  = r_rem - r_div;
    assign mod_done = (r_step == '0);
    assign mod_slot = SLOT_W'(r_rem);

    always_comb begin
        case (r_state)
            S_RD_REP: node_raddr = r_rep_slot;
            S_RD_DST: node_raddr = r_slot_b;
            default:  node_raddr = r_slot_a;
        endcase
    end

    assign node_base = IV_AW'(node_raddr) * IV_AW'(MAX_INTERVALS);
    assign iv_raddr  = r_base + IV_AW'(r_k);
    assign iv_waddr  = r_base + IV_AW'(node_ent.cnt);

    assign issuing = (r_k < r_cnt);
    assign hit     = r_pend && (r_post >= iv_rdata[2*NUM_W-1:NUM_W])
                            && (r_post <= iv_rdata[NUM_W-1:0]);
    assign load_ok = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_out_valid  = r_out_valid && i_stall;
        n_req        = r_req;
        n_node       = r_node;
        n_target     = r_target;
        n_value      = r_value;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_rem        = r_rem;
        n_div        = r_div;
        n_step       = r_step;
        n_mod_sel    = r_mod_sel;
        n_slot_a     = r_slot_a;
        n_slot_b     = r_slot_b;
        n_rep_slot   = r_rep_slot;
        n_post       = r_post;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_pend       = r_pend;
        n_base       = r_base;
        n_res_reach  = r_res_reach;
        n_res_status = r_res_status;
        n_out_reach  = r_out_reach;
        n_out_status = r_out_status;
        node_we      = 1'b0;
        node_waddr   = r_slot_a;
        node_wdata   = node_ent;
        iv_we        = 1'b0;

        case (r_state)
            S_CLEAR: begin
                node_we    = 1'b1;
                node_waddr = r_clr_addr;
                node_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req        = t_req'(i_req_type);
                    n_node       = i_node;
                    n_target     = i_target_node;
                    n_value      = i_value;
                    n_lo         = i_low_bound;
                    n_hi         = i_high_bound;
                    n_res_reach  = 1'b0;
                    n_res_status = 1'b0;
                    n_rem        = {1'b0, i_node};
                    n_div        = NUM_W'(DIV_INIT);
                    n_step       = STEP_W'(MOD_STEPS);
                    n_mod_sel    = 1'b0;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                if (!mod_done) begin
                    if (mod_ge) begin
                        n_rem = mod_sub;
                    end
                    n_div  = r_div >> 1;
                    n_step = r_step - 1'b1;
                end else if (!r_mod_sel) begin
                    n_slot_a = mod_slot;
                    n_div    = NUM_W'(DIV_INIT);
                    n_step   = STEP_W'(MOD_STEPS);
                    case (r_req)
                        REQ_QUERY: begin
                            // equal raw ids never reach each other
                            if (r_node == r_target) begin
                                n_state = S_DONE;
                            end else begin
                                n_rem     = {1'b0, r_target};
                                n_mod_sel = 1'b1;
                            end
                        end
                        REQ_SET_REP: begin
                            n_rem     = r_value;
                            n_mod_sel = 1'b1;
                        end
                        REQ_SET_POST, REQ_APPEND, REQ_CLEAR: begin
                            n_state = S_RD_A;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    n_slot_b = mod_slot;
                    n_state  = S_RD_A;
                end
            end
            S_RD_A: begin
                n_base  = node_base;
                n_state = S_GOT_A;
            end
            S_GOT_A: begin
                n_state = S_DONE;
                case (r_req)
                    REQ_QUERY: begin
                        if (node_ent.valid) begin
                            n_rep_slot = node_ent.rep;
                            n_state    = S_RD_REP;
                        end else begin
                            n_post  = node_ent.post;
                            n_state = S_RD_DST;
                        end
                    end
                    REQ_SET_REP: begin
                        node_we          = 1'b1;
                        node_wdata.valid = 1'b1;
                        node_wdata.rep   = r_slot_b;
                    end
                    REQ_SET_POST: begin
                        node_we         = 1'b1;
                        node_wdata.post = r_value;
                    end
                    REQ_APPEND: begin
                        if (node_ent.cnt >= CNT_W'(MAX_INTERVALS)) begin
                            n_res_status = 1'b1;
                        end else begin
                            iv_we          = 1'b1;
                            node_we        = 1'b1;
                            node_wdata.cnt = node_ent.cnt + 1'b1;
                        end
                    end
                    REQ_CLEAR: begin
                        node_we        = 1'b1;
                        node_wdata.cnt = '0;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD_REP: begin
                n_state = S_GOT_REP;
            end
            S_GOT_REP: begin
                n_post  = node_ent.post;
                n_state = S_RD_DST;
            end
            S_RD_DST: begin
                n_base  = node_base;
                n_state = S_GOT_DST;
            end
            S_GOT_DST: begin
                n_cnt  = node_ent.cnt;
                n_k    = '0;
                n_pend = 1'b0;
                if (node_ent.cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // read of interval k overlaps the check of interval k-1
                if (hit) begin
                    n_res_reach = 1'b1;
                    n_state     = S_DONE;
                end else if (!issuing && !r_pend) begin
                    n_state = S_DONE;
                end else begin
                    n_pend = issuing;
                    if (issuing) begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (load_ok) begin
                    n_out_valid  = 1'b1;
                    n_out_reach  = r_res_reach;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_node       <= n_node;
        r_target     <= n_target;
        r_value      <= n_value;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_step       <= n_step;
        r_mod_sel    <= n_mod_sel;
        r_slot_a     <= n_slot_a;
        r_slot_b     <= n_slot_b;
        r_rep_slot   <= n_rep_slot;
        r_post       <= n_post;
        r_cnt        <= n_cnt;
        r_k          <= n_k;
        r_pend       <= n_pend;
        r_base       <= n_base;
        r_res_reach  <= n_res_reach;
        r_res_status <= n_res_status;
        r_out_reach  <= n_out_reach;
        r_out_status <= n_out_status;
    end

    // node table: representative flag and id, post-order number, interval count
    ilr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // interval table: {low, high} per slot, MAX_INTERVALS rows per node
    ilr_ram #(
        .WIDTH (2 * NUM_W),
        .DEPTH (IV_DEPTH)
    ) u_iv_ram (
        .i_clk   (i_clk),
        .i_we    (iv_we),
        .i_waddr (iv_waddr),
        .i_wdata ({r_lo, r_hi}),
        .i_raddr (iv_raddr),
        .o_rdata (iv_rdata)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_reachable = r_out_reach;
    assign o_status    = r_out_status;

    a_mod_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_step == '0) |-> (32'(r_rem) < NODES))
        else $error("remainder unit finished outside the slot range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GOT_DST) |-> (node_ent.cnt <= CNT_W'(MAX_INTERVALS)))
        else $error("stored interval count above list capacity");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_cnt))
        else $error("interval scan ran past the stored count");

    a_transfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_MOD))
        else $error("input transfer did not start the remainder unit");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result presented without a finished item");

endmodule

FILE: sim/ilr_reachability_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilr_reachability_checker
// Watches both channels of the interval label reachability unit. It keeps
// its own copy of the node and interval tables, works out the answer of
// every transfer in and compares each transfer out with the oldest answer.
// ----------------------------------------------------------------------------
module ilr_reachability_checker
    import ilr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [ID_W-1:0]  i_node,
    input  logic [ID_W-1:0]  i_target_node,
    input  logic [NUM_W-1:0] i_value,
    input  logic [NUM_W-1:0] i_low_bound,
    input  logic [NUM_W-1:0] i_high_bound,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic             i_reachable,
    input  logic             i_status,
    output int               o_fail_count,
    output int               o_outstanding
);

    localparam int NODE_COUNT = 1024;
    localparam int LIST_DEPTH = 8;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic reachable;
        logic status;
    } t_answer;

    logic             rep_set    [NODE_COUNT];
    logic [ID_W-1:0]  rep_of     [NODE_COUNT];
    logic [NUM_W-1:0] post_of    [NODE_COUNT];
    int unsigned      list_len   [NODE_COUNT];
    logic [NUM_W-1:0] bound_low  [NODE_COUNT*LIST_DEPTH];
    logic [NUM_W-1:0] bound_high [NODE_COUNT*LIST_DEPTH];

    t_answer     answers_due[$];
    int unsigned results_seen;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTS)
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        o_fail_count++;
    endtask

    function automatic logic reach_answer(input logic [ID_W-1:0] src_id,
                                          input logic [ID_W-1:0] dst_id);
        int unsigned      src;
        int unsigned      dst;
        int unsigned      n;
        logic [NUM_W-1:0] pn;
        logic             hit;
        hit = 1'b0;
        // a node never reaches itself here, self interval or not
        if (src_id != dst_id) begin
            src = src_id % NODE_COUNT;
            if (rep_set[src])
                src = rep_of[src] % NODE_COUNT;
            pn  = post_of[src];
            dst = dst_id % NODE_COUNT;
            n   = (list_len[dst] > LIST_DEPTH) ? LIST_DEPTH : list_len[dst];
            for (int k = 0; k < n; k++) begin
                if (pn >= bound_low[dst*LIST_DEPTH + k] && pn <= bound_high[dst*LIST_DEPTH + k])
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_answer apply_request(input logic [REQ_W-1:0] req,
                                              input logic [ID_W-1:0]  node,
                                              input logic [ID_W-1:0]  target,
                                              input logic [NUM_W-1:0] value,
                                              input logic [NUM_W-1:0] lo,
                                              input logic [NUM_W-1:0] hi);
        t_answer     ans;
        int unsigned slot;
        int unsigned pos;
        ans  = '0;
        slot = node % NODE_COUNT;
        case (req)
            REQ_QUERY: begin
                ans.reachable = reach_answer(node, target);
            end
            REQ_SET_REP: begin
                rep_of[slot]  = ID_W'(value % NODE_COUNT);
                rep_set[slot] = 1'b1;
            end
            REQ_SET_POST: begin
                post_of[slot] = value;
            end
            REQ_APPEND: begin
                if (list_len[slot] >= LIST_DEPTH) begin
                    ans.status = 1'b1;
                end else begin
                    pos             = slot*LIST_DEPTH + list_len[slot];
                    bound_low[pos]  = lo;
                    bound_high[pos] = hi;
                    list_len[slot]  = list_len[slot] + 1;
                end
            end
            REQ_CLEAR: begin
                list_len[slot] = 0;
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        t_answer due;
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                rep_set[i]  = 1'b0;
                post_of[i]  = '0;
                list_len[i] = 0;
            end
            answers_due.delete();
            o_fail_count = 0;
            results_seen = 0;
        end else begin
            // result side first: an answer always leaves after its own request
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got = '{reachable: i_reachable, status: i_status};
                if (answers_due.size() == 0) begin
                    report_mismatch("result with no request waiting");
                end else begin
                    want = answers_due.pop_front();
                    if (got.reachable !== want.reachable)
                        report_mismatch($sformatf("reachable %b, expected %b",
                                                  got.reachable, want.reachable));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  got.status, want.status));
                end
                results_seen++;
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                due = apply_request(i_req_type, i_node, i_target_node,
                                    i_value, i_low_bound, i_high_bound);
                answers_due.insert(answers_due.size(), due);
            end
        end
        o_outstanding = answers_due.size();
    end

endmodule

FILE: sim/tb_interval_label_reachability_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_label_reachability_unit
// Drives the reachability unit with directed corner requests and then with
// random table writes and queries over a small pool of nodes, under three
// idling patterns. The checker beside the block does all predicting.
// ----------------------------------------------------------------------------
module tb_interval_label_reachability_unit
    import ilr_pkg::*;
;

    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int POOL_SIZE       = 16;
    localparam int LIST_DEPTH      = 8;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [REQ_W-1:0] i_req_type;
    logic [ID_W-1:0]  i_node;
    logic [ID_W-1:0]  i_target_node;
    logic [NUM_W-1:0] i_value;
    logic [NUM_W-1:0] i_low_bound;
    logic [NUM_W-1:0] i_high_bound;
    logic             o_valid;
    logic             i_stall;
    logic             o_reachable;
    logic             o_status;

    int fail_count;
    int outstanding;
    int send_idle;
    int recv_idle;
    int cycle_count = 0;

    logic [ID_W-1:0] node_pool [POOL_SIZE];

    interval_label_reachability_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_node        (i_node),
        .i_target_node (i_target_node),
        .i_value       (i_value),
        .i_low_bound   (i_low_bound),
        .i_high_bound  (i_high_bound),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_reachable   (o_reachable),
        .o_status      (o_status)
    );

    ilr_reachability_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_req_type    (i_req_type),
        .i_node        (i_node),
        .i_target_node (i_target_node),
        .i_value       (i_value),
        .i_low_bound   (i_low_bound),
        .i_high_bound  (i_high_bound),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_reachable   (o_reachable),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle);

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [ID_W-1:0]  node,
                                input logic [ID_W-1:0]  target,
                                input logic [NUM_W-1:0] value,
                                input logic [NUM_W-1:0] lo,
                                input logic [NUM_W-1:0] hi);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_node        <= node;
        i_target_node <= target;
        i_value       <= value;
        i_low_bound   <= lo;
        i_high_bound  <= hi;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic wait_all_answered();
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_node();
        if ($urandom_range(7) == 0)
            return ID_W'($urandom_range(2**ID_W - 1));
        return node_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // small numbers most of the time so post-order numbers land in intervals
    function automatic logic [NUM_W-1:0] pick_number();
        if ($urandom_range(3) == 0)
            return NUM_W'($urandom_range(ID_SPAN - 1));
        return NUM_W'($urandom_range(31));
    endfunction

    task automatic send_random_request();
        int               sel;
        logic [REQ_W-1:0] req;
        logic [NUM_W-1:0] value;
        logic [NUM_W-1:0] lo;
        logic [NUM_W-1:0] hi;
        sel   = $urandom_range(99);
        value = pick_number();
        lo    = pick_number();
        hi    = ($urandom_range(4) == 0) ? pick_number() : NUM_W'(lo + $urandom_range(8));
        if (sel < 40) begin
            req = REQ_QUERY;
        end else if (sel < 50) begin
            req = REQ_SET_REP;
            if ($urandom_range(3) != 0)
                value = NUM_W'(pick_node());
            else
                value = NUM_W'($urandom_range(ID_SPAN - 1));
        end else if (sel < 65) begin
            req = REQ_SET_POST;
        end else if (sel < 92) begin
            req = REQ_APPEND;
        end else if (sel < 97) begin
            req = REQ_CLEAR;
        end else begin
            req = REQ_W'($urandom_range(2**REQ_W - 1, REQ_CLEAR + 1));
        end
        send_request(req, pick_node(), pick_node(), value, lo, hi);
    endtask

    task automatic send_directed();
        // empty tables: unset post-order number reads as zero
        send_request(REQ_QUERY,    10'd0,    10'd1,    '0,     '0,     '0);
        send_request(REQ_APPEND,   10'd1,    10'd0,    '0,     11'd0,  11'd0);
        send_request(REQ_QUERY,    10'd0,    10'd1,    '1,     '1,     '1);
        // same source and target never reaches, even inside its own interval
        send_request(REQ_QUERY,    10'd1,    10'd1,    '0,     '0,     '0);
        send_request(REQ_SET_POST, 10'd5,    10'd0,    '1,     '0,     '0);
        send_request(REQ_APPEND,   10'd1,    10'd0,    '0,     '1,     '1);
        send_request(REQ_QUERY,    10'd5,    10'd1,    '0,     '0,     '0);
        // interval with low above high never matches
        send_request(REQ_APPEND,   10'd2,    10'd0,    '0,     '1,     11'd0);
        send_request(REQ_QUERY,    10'd5,    10'd2,    '0,     '0,     '0);
        // representative id above the node range folds to 5
        send_request(REQ_SET_REP,  10'd7,    10'd0,    11'd1029, '0,   '0);
        send_request(REQ_QUERY,    10'd7,    10'd1,    '0,     '0,     '0);
        send_request(REQ_SET_REP,  10'd1023, 10'd1023, '1,     '0,     '0);
        send_request(REQ_SET_POST, 10'd1023, 10'd0,    11'd1024, '0,   '0);
        send_request(REQ_APPEND,   10'd0,    10'd0,    '0,     11'd1024, 11'd1024);
        send_request(REQ_QUERY,    10'd1022, 10'd0,    '0,     '0,     '0);
        send_request(REQ_QUERY,    10'd1023, 10'd0,    '0,     '0,     '0);
        // fill one list, then one append more is refused
        for (int k = 0; k <= LIST_DEPTH; k++)
            send_request(REQ_APPEND, 10'd3, 10'd0, '0, NUM_W'(k), NUM_W'(k + 1));
        send_request(REQ_CLEAR,    10'd3,    10'd0,    '0,     '0,     '0);
        send_request(REQ_APPEND,   10'd3,    10'd0,    '0,     11'd0,  '1);
        for (int r = REQ_CLEAR + 1; r < 2**REQ_W; r++)
            send_request(REQ_W'(r), '1, '1, '1, '1, '1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = REQ_QUERY;
        i_node        = '0;
        i_target_node = '0;
        i_value       = '0;
        i_low_bound   = '0;
        i_high_bound  = '0;
        send_idle     = 29;
        recv_idle     = 82;
        for (int i = 0; i < POOL_SIZE; i++)
            node_pool[i] = ID_W'($urandom_range(2**ID_W - 1));
        node_pool[0] = '0;
        node_pool[1] = '1;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_directed();
        repeat (ITEMS_PER_PHASE) send_random_request();
        // sender holds off until the block has answered everything
        wait_all_answered();

        send_idle = 82;
        recv_idle = 29;
        repeat (ITEMS_PER_PHASE) send_random_request();

        send_idle = 0;
        recv_idle = 0;
        repeat (ITEMS_PER_PHASE) send_random_request();

        wait_all_answered();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
